@@ hdl/mesh_classification_projector_core_defines.svh @@
// ----------------------------------------------------------------------------
// Mesh classification projector: assertion macros
// Shared helpers for writing clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MESH_CLASSIFICATION_PROJECTOR_CORE_DEFINES_SVH
`define MESH_CLASSIFICATION_PROJECTOR_CORE_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define MCP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("mesh classification projector check failed");

// Assertion that is also checked while reset is held.
`define MCP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("mesh classification projector check failed");

`endif

@@ hdl/mcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh classification projector package
// Widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package mcp_pkg;

    localparam int ID_BITS    = 32;  // width of the held class id
    localparam int FIELD_ID_W = 32;  // width of the id fields on the ports
    localparam int DIM_W      = 2;
    localparam int CNT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_DIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAXED    = 1'd1;

    typedef logic signed [ID_BITS-1:0]    t_id;
    typedef logic signed [FIELD_ID_W-1:0] t_field_id;
    typedef logic [DIM_W-1:0]             t_dim;
    typedef logic [CNT_W-1:0]             t_cnt;

    localparam t_id  ID_NONE   = '1;
    localparam t_cnt CNT_MAX   = '1;
    localparam t_cnt CNT_PAIR  = 2'd2;

    typedef struct packed {
        t_dim entity_dim;
        logic relaxed;
    } t_cfg;

    typedef struct packed {
        logic start_entity;
        logic neighbour_valid;
        logic last_item;
        t_dim own_dim;
        t_id  own_id;
        t_dim neighbour_dim;
        t_id  neighbour_id;
    } t_item;

    typedef struct packed {
        t_dim class_dim;
        t_id  best_id;
        t_cnt agree_cnt;
    } t_state;

    typedef struct packed {
        t_dim      dim;
        t_field_id id;
    } t_result;

endpackage

@@ hdl/mesh_classification_projector_core.sv @@
// ----------------------------------------------------------------------------
// Mesh classification projector core
// Folds a mesh entity's own classification with those of its higher
// dimensional neighbours into one final model dimension and id.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_stall), one per
// neighbour, framed by start_entity on the first request of an entity and
// last_item on its final request. A request is taken at a clock edge with
// i_in_valid high and o_in_stall low. The request with last_item set yields
// one result on the output channel (o_out_valid / i_out_stall); all others
// yield none.
// The edge that takes the last request loads the input register; once the
// result slot is free, an edge moves it through the update logic into the
// result register, which drives o_out_valid. Throughput is one request per
// cycle, set by the state update loop around the classification registers,
// unless a request with last_item waits on a stalled result.
// When the receiver stalls, the result register holds; a following request
// without last_item still moves on, and one with last_item waits in the input
// register, which raises o_in_stall until the result is taken.
// Reset clears both channels, the configuration and the held classification
// (dimension zero, id none, count zero). Configuration writes are taken on
// any cycle with i_cfg_we high and must happen only while the block is idle.
// ----------------------------------------------------------------------------
module mesh_classification_projector_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_we,
    input  logic [mcp_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [mcp_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    // request channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_start_entity,
    input  logic                                     i_neighbour_valid,
    input  logic                                     i_last_item,
    input  logic [mcp_pkg::DIM_W-1:0]                i_own_dim,
    input  logic signed [mcp_pkg::FIELD_ID_W-1:0]    i_own_id,
    input  logic [mcp_pkg::DIM_W-1:0]                i_neighbour_dim,
    input  logic signed [mcp_pkg::FIELD_ID_W-1:0]    i_neighbour_id,
    // result channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [mcp_pkg::DIM_W-1:0]                o_result_dim,
    output logic signed [mcp_pkg::FIELD_ID_W-1:0]    o_result_id
);
    import mcp_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    t_item   r_s1_item;
    t_state  r_state;
    logic    r_out_valid;
    t_result r_out;

    t_state  n_state;
    t_result n_result;
    logic    out_free;
    logic    s1_fire;
    logic    in_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTITY_DIM: r_cfg.entity_dim <= i_cfg_data;
                CFG_RELAXED:    r_cfg.relaxed    <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // The result slot is free when empty or being drained this cycle.
    // Only a request that produces a result needs the slot to move on.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (!r_s1_item.last_item || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: ids are widened or cut to the held id width here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.start_entity    <= i_start_entity;
            r_s1_item.neighbour_valid <= i_neighbour_valid;
            r_s1_item.last_item       <= i_last_item;
            r_s1_item.own_dim         <= i_own_dim;
            r_s1_item.own_id          <= ID_BITS'(i_own_id);
            r_s1_item.neighbour_dim   <= i_neighbour_dim;
            r_s1_item.neighbour_id    <= ID_BITS'(i_neighbour_id);
        end
    end

    mcp_update u_update (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_s1_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Running classification, updated once per request leaving the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.class_dim <= '0;
            r_state.best_id   <= ID_NONE;
            r_state.agree_cnt <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_item.last_item) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_item.last_item) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_result_dim = r_out.dim;
    assign o_result_id  = r_out.id;

endmodule

@@ hdl/mcp_update.sv @@
// ----------------------------------------------------------------------------
// Mesh classification projector: item update
// Next classification state and final result for one request.
// ----------------------------------------------------------------------------
module mcp_update (
    input  mcp_pkg::t_cfg    i_cfg,
    input  mcp_pkg::t_state  i_state,
    input  mcp_pkg::t_item   i_item,
    output mcp_pkg::t_state  o_state,
    output mcp_pkg::t_result o_result
);
    import mcp_pkg::*;

    t_state     cur;
    t_state     nxt;
    logic       conflict;
    logic [2:0] ent_plus;
    logic [2:0] best_ext;
    logic       demote;

    function automatic t_cnt sat_inc(input t_cnt c);
        t_cnt r;
        r = (c == CNT_MAX) ? c : c + t_cnt'(1);
        return r;
    endfunction

    always_comb begin
        cur = i_state;
        if (i_item.start_entity) begin
            cur.class_dim = i_item.own_dim;
            cur.best_id   = i_item.own_id;
            cur.agree_cnt = '0;
        end

        conflict = (i_item.neighbour_id != cur.best_id) &&
                   (!i_cfg.relaxed || (i_item.neighbour_id != ID_NONE));

        nxt = cur;
        if (i_item.neighbour_valid) begin
            if (i_item.neighbour_dim < cur.class_dim) begin
                nxt.class_dim = i_item.neighbour_dim;
                nxt.best_id   = i_item.neighbour_id;
                nxt.agree_cnt = t_cnt'(1);
            end else if (i_item.neighbour_dim == cur.class_dim) begin
                if (!conflict) begin
                    nxt.agree_cnt = sat_inc(cur.agree_cnt);
                end else if (cur.best_id == ID_NONE) begin
                    nxt.best_id   = i_item.neighbour_id;
                    nxt.agree_cnt = sat_inc(cur.agree_cnt);
                end else begin
                    // A true conflict drops one dimension, never below zero.
                    nxt.class_dim = (cur.class_dim == '0) ? cur.class_dim
                                                          : cur.class_dim - t_dim'(1);
                    nxt.best_id   = ID_NONE;
                    nxt.agree_cnt = '0;
                end
            end
        end
    end

    // Final dimension test; it only shapes the result, not the state.
    always_comb begin
        ent_plus = {1'b0, i_cfg.entity_dim} + 3'd1;
        best_ext = {1'b0, nxt.class_dim};
        demote   = ((nxt.agree_cnt != CNT_PAIR) && (best_ext == ent_plus)) ||
                   ((nxt.agree_cnt < CNT_PAIR) && (best_ext > ent_plus));
        if (demote) begin
            o_result.dim = i_cfg.entity_dim;
            o_result.id  = FIELD_ID_W'(ID_NONE);
        end else begin
            o_result.dim = nxt.class_dim;
            o_result.id  = FIELD_ID_W'(nxt.best_id);
        end
    end

    assign o_state = nxt;

endmodule

@@ hdl/mcp_checker.sv @@
// ----------------------------------------------------------------------------
// Mesh classification projector checker
// Port-level checks on the core, attached with a bind statement.
// ----------------------------------------------------------------------------
`include "mesh_classification_projector_core_defines.svh"

module mcp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic                                  i_last_item,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic [mcp_pkg::DIM_W-1:0]             o_result_dim,
    input  logic signed [mcp_pkg::FIELD_ID_W-1:0] o_result_id
);
    import mcp_pkg::*;

    // A stalled result stays offered with the same payload.
    `MCP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `MCP_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable({o_result_dim, o_result_id}))

    // Back-pressure only comes from a full, stalled result register.
    `MCP_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))

    // A taken last request is followed by o_out_valid high.
    `MCP_ASSERT(a_last_result, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_last_item |=> ##1 o_out_valid)

    // Reset empties the result channel.
    `MCP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind mesh_classification_projector_core mcp_checker u_mcp_checker (.*);
